/* src/jsu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types, character codes and helpers for the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  // result codes carried by the end item
  typedef enum logic [2:0] {
    ERR_OK          = 3'd0,
    ERR_FRAMING     = 3'd1,
    ERR_BARE_QUOTE  = 3'd2,
    ERR_UNKNOWN_ESC = 3'd3,
    ERR_BAD_HEX     = 3'd4,
    ERR_CUT_OFF     = 3'd5
  } err_t;

  // characters the parser reacts to
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;

  // control bytes produced by the single-letter escapes
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_HT = 8'h09;

  // bytes still copied verbatim after a unicode escape
  localparam logic [2:0] UNI_COPY_LEN = 3'd4;

  // one result item
  typedef struct packed {
    logic [7:0] data;
    logic       is_end;
    err_t       code;
  } item_t;

  // hex character decode: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c inside {[8'h30:8'h39]}) begin
      return {1'b1, c[3:0]};
    end else if (c inside {[8'h61:8'h66]}) begin
      d = c - 8'h57;
      return {1'b1, d[3:0]};
    end else if (c inside {[8'h41:8'h46]}) begin
      d = c - 8'h37;
      return {1'b1, d[3:0]};
    end
    return 5'b0_0000;
  endfunction

endpackage : jsu_pkg
`default_nettype wire

/* src/json_string_unescaper_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// json_string_unescaper_core
// Streaming decoder for one quoted JSON string: checks the framing quotes,
// decodes backslash escapes (a unicode escape is copied through as written)
// and closes each string with an end item that carries its error code.
// ----------------------------------------------------------------------------
//  channel | direction | handshake          | payload
//  in      | input     | in_valid/in_stall  | in_byte, in_last
//  out     | output    | out_valid/out_stall| out_byte, is_end, error_code
//
//  One input request per cycle while in_stall is low; its results are in the
//  result queue in the cycle after acceptance. A unicode escape writes two
//  results at once into the four-entry result queue, so in_stall rises while
//  the queue holds three or more entries. Synchronous active-high reset empties
//  the queue and returns the parser to waiting for an opening quote.
// ----------------------------------------------------------------------------
module json_string_unescaper_core (
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       in_byte,
  input  wire              in_last,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [7:0]       out_byte,
  output logic             is_end,
  output logic [2:0]       error_code
);
  import jsu_pkg::*;

  typedef enum logic [2:0] {
    PH_OPEN   = 3'd0,
    PH_BODY   = 3'd1,
    PH_ESC    = 3'd2,
    PH_HEX_HI = 3'd3,
    PH_HEX_LO = 3'd4,
    PH_UNI    = 3'd5,
    PH_SKIP   = 3'd6
  } phase_t;

  // parser state
  phase_t     phase, phase_next;
  logic [2:0] unicode_left, unicode_left_next;
  logic [7:0] hex_high, hex_high_next;
  err_t       pend_err, pend_err_next;

  // result queue
  item_t      queue [4];
  logic [1:0] wptr, rptr;
  logic [2:0] count, count_next;

  logic       in_acc, out_acc;
  logic [1:0] n_items;
  item_t      item0, item1;
  logic [4:0] hex_hi_dec, hex_lo_dec;
  logic [2:0] left_dec;
  err_t       end_code;

  // handshakes
  assign in_stall  = (count > 3'd2);
  assign in_acc    = in_valid && !in_stall;
  assign out_valid = (count != 3'd0);
  assign out_acc   = out_valid && !out_stall;

  assign hex_hi_dec = hex_digit(hex_high);
  assign hex_lo_dec = hex_digit(in_byte);
  assign left_dec   = (unicode_left != 3'd0) ? unicode_left - 3'd1 : 3'd0;

  // code of the end item
  always_comb begin
    if (phase == PH_OPEN) begin
      end_code = ERR_FRAMING;
    end else if (in_byte != CH_QUOTE) begin
      end_code = ERR_FRAMING;
    end else if (pend_err != ERR_OK) begin
      end_code = pend_err;
    end else if (phase == PH_ESC || phase == PH_HEX_HI || phase == PH_HEX_LO) begin
      end_code = ERR_CUT_OFF;
    end else begin
      end_code = ERR_OK;
    end
  end

  // decode one byte
  always_comb begin
    phase_next        = phase;
    unicode_left_next = unicode_left;
    hex_high_next     = hex_high;
    pend_err_next     = pend_err;
    n_items           = 2'd0;
    item0             = '{data: in_byte, is_end: 1'b0, code: ERR_OK};
    item1             = '{data: CH_U, is_end: 1'b0, code: ERR_OK};
    if (in_last) begin
      n_items           = 2'd1;
      item0             = '{data: 8'h00, is_end: 1'b1, code: end_code};
      phase_next        = PH_OPEN;
      unicode_left_next = 3'd0;
      hex_high_next     = 8'h00;
      pend_err_next     = ERR_OK;
    end else begin
      case (phase)
        PH_OPEN: begin
          if (in_byte == CH_QUOTE) begin
            phase_next = PH_BODY;
          end else begin
            phase_next    = PH_SKIP;
            pend_err_next = ERR_FRAMING;
          end
        end
        PH_BODY: begin
          if (in_byte == CH_QUOTE) begin
            phase_next    = PH_SKIP;
            pend_err_next = ERR_BARE_QUOTE;
          end else if (in_byte == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            n_items = 2'd1;
          end
        end
        PH_ESC: begin
          phase_next = PH_BODY;
          case (in_byte)
            CH_BSLASH, CH_QUOTE, CH_SLASH: n_items = 2'd1;
            CH_B: begin
              n_items    = 2'd1;
              item0.data = BYTE_BS;
            end
            CH_F: begin
              n_items    = 2'd1;
              item0.data = BYTE_FF;
            end
            CH_R: begin
              n_items    = 2'd1;
              item0.data = BYTE_CR;
            end
            CH_N: begin
              n_items    = 2'd1;
              item0.data = BYTE_LF;
            end
            CH_T: begin
              n_items    = 2'd1;
              item0.data = BYTE_HT;
            end
            CH_U: begin
              n_items           = 2'd2;
              item0.data        = CH_BSLASH;
              unicode_left_next = UNI_COPY_LEN;
              phase_next        = PH_UNI;
            end
            CH_X: phase_next = PH_HEX_HI;
            default: begin
              phase_next    = PH_SKIP;
              pend_err_next = ERR_UNKNOWN_ESC;
            end
          endcase
        end
        PH_HEX_HI: begin
          hex_high_next = in_byte;
          phase_next    = PH_HEX_LO;
        end
        PH_HEX_LO: begin
          hex_high_next = 8'h00;
          if (!hex_hi_dec[4] || !hex_lo_dec[4]) begin
            phase_next    = PH_SKIP;
            pend_err_next = ERR_BAD_HEX;
          end else begin
            n_items    = 2'd1;
            item0.data = {hex_hi_dec[3:0], hex_lo_dec[3:0]};
            phase_next = PH_BODY;
          end
        end
        PH_UNI: begin
          n_items           = 2'd1;
          unicode_left_next = left_dec;
          if (left_dec == 3'd0) begin
            phase_next = PH_BODY;
          end
        end
        default: ;
      endcase
    end
  end

  // queue occupancy
  always_comb begin
    count_next = count;
    if (in_acc) begin
      count_next = count_next + {1'b0, n_items};
    end
    if (out_acc) begin
      count_next = count_next - 3'd1;
    end
  end

  // state and result queue
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OPEN;
      unicode_left <= 3'd0;
      hex_high     <= 8'h00;
      pend_err     <= ERR_OK;
      wptr         <= 2'd0;
      rptr         <= 2'd0;
      count        <= 3'd0;
    end else begin
      count <= count_next;
      if (out_acc) begin
        rptr <= rptr + 2'd1;
      end
      if (in_acc) begin
        phase        <= phase_next;
        unicode_left <= unicode_left_next;
        hex_high     <= hex_high_next;
        pend_err     <= pend_err_next;
        wptr         <= wptr + n_items;
        if (n_items != 2'd0) begin
          queue[wptr] <= item0;
        end
        if (n_items == 2'd2) begin
          queue[wptr + 2'd1] <= item1;
        end
      end
    end
  end

  // output fields
  assign out_byte   = queue[rptr].data;
  assign is_end     = queue[rptr].is_end;
  assign error_code = queue[rptr].code;

  // checks
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_last |=> phase == PH_OPEN)
    else $error("parser not back at opening quote after string end");

  a_uni_left: assert property (@(posedge clk) disable iff (rst)
    unicode_left != 3'd0 |-> phase == PH_UNI)
    else $error("unicode copy count live outside unicode phase");

  a_queue_bound: assert property (@(posedge clk) disable iff (rst)
    count <= 3'd4)
    else $error("result queue overfilled");

  a_end_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_end |-> out_byte == 8'h00)
    else $error("end item carries a data byte");

  a_data_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_end |-> error_code == 3'd0)
    else $error("data item carries an error code");

endmodule : json_string_unescaper_core
`default_nettype wire
